// ===== design/nbg_pkg.sv =====
// Package for the n-body gravity Euler step unit: fixed-point constants, command,
// register and arithmetic-unit codes, and the request type of the shared unit.
// Depends on nothing; nbg_alu, the top level and the testbench use it by scoped names.
package nbg_pkg;

	// Fixed-point format of positions, velocities, masses and forces.
	localparam int FRAC_BITS = 16;
	// Magnitude width after capping to 2^(64-FRAC_BITS)-1.
	localparam int MAG_W = 64 - FRAC_BITS;

	// Operand and result widths of the shared arithmetic unit.
	localparam int ALU_A_W = 68;
	localparam int ALU_B_W = 34;
	localparam int ALU_R_W = 82;
	localparam int ALU_CNT_W = 7;
	localparam int MUL_STEPS = ALU_B_W;
	localparam int DIV_STEPS = 64;
	localparam int SQRT_STEPS = ALU_A_W / 2;

	localparam logic [1:0] ALU_MUL = 2'd0;
	localparam logic [1:0] ALU_DIV = 2'd1;
	localparam logic [1:0] ALU_SQRT = 2'd2;

	localparam logic [2:0] CMD_LOAD_POS = 3'd0;
	localparam logic [2:0] CMD_LOAD_VEL = 3'd1;
	localparam logic [2:0] CMD_LOAD_MASS = 3'd2;
	localparam logic [2:0] CMD_ADD_FORCE = 3'd3;
	localparam logic [2:0] CMD_STEP = 3'd4;

	localparam logic [1:0] REG_GRAVITY = 2'd0;
	localparam logic [1:0] REG_TIME_STEP = 2'd1;
	localparam logic [1:0] REG_BODY_COUNT = 2'd2;

	localparam logic [15:0] TIME_STEP_RESET = 16'd1092;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} alu_req_t;

endpackage

// ===== design/nbg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module nbg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/nbg_alu.sv =====
// Shared bit-serial arithmetic unit: multiply, divide and square root, one bit per cycle.
// Depends on nbg_pkg.
module nbg_alu (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nbg_pkg::alu_req_t            req,
	input  logic [nbg_pkg::ALU_A_W-1:0]  opa,
	input  logic [nbg_pkg::ALU_B_W-1:0]  opb,
	output logic                         done,
	output logic [nbg_pkg::ALU_R_W-1:0]  result
);

	logic [nbg_pkg::ALU_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [1:0]                    op_q;
	logic [nbg_pkg::ALU_R_W-1:0]   x_q;
	logic [nbg_pkg::ALU_B_W-1:0]   y_q;
	logic [nbg_pkg::ALU_R_W-1:0]   acc_q;
	logic [37:0]                   rem_q;
	logic [nbg_pkg::ALU_B_W:0]     div_t;
	logic [37:0]                   sq_t;
	logic [37:0]                   sq_trial;

	assign div_t    = {rem_q[nbg_pkg::ALU_B_W-1:0], x_q[63]};
	assign sq_t     = {rem_q[35:0], x_q[nbg_pkg::ALU_A_W-1 -: 2]};
	assign sq_trial = {2'b00, acc_q[nbg_pkg::ALU_B_W-1:0], 2'b01};

	assign done   = done_q;
	assign result = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				case (req.op)
					nbg_pkg::ALU_DIV:  cnt_q <= nbg_pkg::ALU_CNT_W'(nbg_pkg::DIV_STEPS);
					nbg_pkg::ALU_SQRT: cnt_q <= nbg_pkg::ALU_CNT_W'(nbg_pkg::SQRT_STEPS);
					default:           cnt_q <= nbg_pkg::ALU_CNT_W'(nbg_pkg::MUL_STEPS);
				endcase
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == nbg_pkg::ALU_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial-result registers carry no reset.
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			x_q   <= nbg_pkg::ALU_R_W'(opa);
			y_q   <= opb;
			acc_q <= '0;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			case (op_q)
				nbg_pkg::ALU_DIV: begin
					x_q <= x_q << 1;
					if (div_t >= {1'b0, y_q}) begin
						rem_q <= 38'(div_t - {1'b0, y_q});
						acc_q <= {acc_q[nbg_pkg::ALU_R_W-2:0], 1'b1};
					end else begin
						rem_q <= 38'(div_t);
						acc_q <= {acc_q[nbg_pkg::ALU_R_W-2:0], 1'b0};
					end
				end
				nbg_pkg::ALU_SQRT: begin
					x_q <= x_q << 2;
					if (sq_t >= sq_trial) begin
						rem_q <= sq_t - sq_trial;
						acc_q <= {acc_q[nbg_pkg::ALU_R_W-2:0], 1'b1};
					end else begin
						rem_q <= sq_t;
						acc_q <= {acc_q[nbg_pkg::ALU_R_W-2:0], 1'b0};
					end
				end
				default: begin
					if (y_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
			endcase
		end
	end

endmodule

// ===== design/nbody_gravity_euler_step_unit.sv =====
// Top level of the n-body gravity unit with explicit Euler integration.
// Depends on nbg_pkg, nbg_ram and nbg_alu.
//
// Usage. Items arrive on the in_valid/in_ready channel. Load commands write a
// body's position, velocity or mass and flags; the add-force command adds a
// vector to the body's accumulated force, saturating the sum. A step command walks the
// bodies in use in index order and produces one result item per body on the
// out_valid/out_ready channel, with last set on the final body.
// Configuration registers are written on cfg_write with no handshake.
// A load writes its entry straight from the accepted item; an add-force reads
// the old force first and writes the sum back from a second state. A step does
// all its arithmetic for each attracting pair and each body in the shared
// bit-serial unit, which retires one bit per cycle of a multiply, divide or root.
// The block takes one item at a time: in_ready is high only when idle.
// Results sit in an output register; the next body is computed while it
// waits, and the sequencer only holds when a second result is ready before the
// receiver has taken the first.
// Reset clears the configuration to its defaults, drops every flag and
// accumulated force through per-body valid bits, and empties the output
// register. Positions and velocities are undefined until loaded; masses read as zero.
module nbody_gravity_euler_step_unit #(
	parameter int MAX_BODIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [3:0]  body_index,
	input  logic [31:0] vec_x,
	input  logic [31:0] vec_y,
	input  logic [31:0] vec_z,
	input  logic [31:0] body_mass,
	input  logic        takes_gravity,
	input  logic        is_attractor,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  out_index,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [31:0] pos_z,
	output logic [31:0] vel_x,
	output logic [31:0] vel_y,
	output logic [31:0] vel_z,
	output logic        last
);

	localparam int IDX_W = $clog2(MAX_BODIES);
	localparam int CNT_W = $clog2(MAX_BODIES + 1);
	localparam int FB = nbg_pkg::FRAC_BITS;
	localparam int MW = nbg_pkg::MAG_W;

	// Sequencer states.
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_EXEC    = 5'd1;
	localparam logic [4:0] S_FADD    = 5'd2;
	localparam logic [4:0] S_BODY_RD = 5'd3;
	localparam logic [4:0] S_BODY_LD = 5'd4;
	localparam logic [4:0] S_J_CHK   = 5'd5;
	localparam logic [4:0] S_J_LD    = 5'd6;
	localparam logic [4:0] S_SQ      = 5'd7;
	localparam logic [4:0] S_SQRT    = 5'd8;
	localparam logic [4:0] S_MM      = 5'd9;
	localparam logic [4:0] S_GM      = 5'd10;
	localparam logic [4:0] S_QD      = 5'd11;
	localparam logic [4:0] S_FM      = 5'd12;
	localparam logic [4:0] S_U       = 5'd13;
	localparam logic [4:0] S_C       = 5'd14;
	localparam logic [4:0] S_J_NEXT  = 5'd15;
	localparam logic [4:0] S_ACC     = 5'd16;
	localparam logic [4:0] S_DP      = 5'd17;
	localparam logic [4:0] S_WB      = 5'd18;
	localparam logic [4:0] S_EMIT    = 5'd19;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] base, input logic [MW-1:0] mag,
			input logic neg);
		logic signed [MW+1:0] m;
		logic signed [MW+1:0] s;
		m = $signed({2'b00, mag});
		s = $signed({{(MW-30){base[31]}}, base}) + (neg ? -m : m);
		if (s > $signed((MW+2)'(32'h7FFF_FFFF))) begin
			return 32'h7FFF_FFFF;
		end else if (s < -$signed((MW+2)'(33'h0_8000_0000))) begin
			return 32'h8000_0000;
		end
		return s[31:0];
	endfunction

	function automatic logic [MW-1:0] cap_mag(input logic [nbg_pkg::ALU_R_W-1:0] v);
		return (v[nbg_pkg::ALU_R_W-1:MW] != '0) ? '1 : v[MW-1:0];
	endfunction

	// Configuration.
	logic [31:0] gc_q;
	logic [15:0] dt_q;
	logic [4:0]  bc_q;

	// Accepted item.
	logic [2:0]       cmd_q;
	logic [3:0]       bidx_q;
	logic [2:0][31:0] vin_q;
	logic [31:0]      bmass_q;
	logic             tg_q;
	logic             ia_q;

	// Sequencer and working registers.
	logic [4:0]       state_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] n_q;
	logic [1:0]       k_q;
	logic             issued_q;
	logic [31:0]      mi_q;
	logic [31:0]      mj_q;
	logic [2:0][31:0] p_q;
	logic [2:0][31:0] v_q;
	logic [2:0][31:0] f_q;
	logic [2:0][32:0] mg_q;
	logic [2:0]       neg_q;
	logic [67:0]      sum_q;
	logic [33:0]      d_q;
	logic [63:0]      t_q;
	logic [MW-1:0]    fm_q;

	logic [MAX_BODIES-1:0] mass_vld_q;
	logic [MAX_BODIES-1:0] force_vld_q;
	logic                  mvld_rd_q;
	logic                  fvld_rd_q;

	logic        out_valid_q;
	logic [3:0]  out_index_q;
	logic [2:0][31:0] out_pos_q;
	logic [2:0][31:0] out_vel_q;
	logic        out_last_q;

	// Memories and their ports.
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             pos_we;
	logic             vel_we;
	logic             mass_we;
	logic             force_we;
	logic [95:0]      pos_wdata;
	logic [95:0]      vel_wdata;
	logic [95:0]      force_wdata;
	logic [95:0]      pos_rdata;
	logic [95:0]      vel_rdata;
	logic [33:0]      mass_rdata;
	logic [95:0]      force_rdata;
	logic [31:0]      mass_eff;
	logic [2:0][31:0] force_eff;
	logic             attr_eff;
	logic             idx_ok;

	// Shared unit.
	nbg_pkg::alu_req_t              alu_req;
	logic [nbg_pkg::ALU_A_W-1:0]    alu_a;
	logic [nbg_pkg::ALU_B_W-1:0]    alu_b;
	logic                           alu_done;
	logic [nbg_pkg::ALU_R_W-1:0]    alu_res;
	logic                           computing;
	logic                           fin;

	logic [2:0][32:0] dx_mag;
	logic [2:0]       dx_neg;
	logic [CNT_W-1:0] n_next;
	logic [CNT_W-1:0] i_inc;

	assign idx_ok = (int'(bidx_q) < MAX_BODIES);
	assign n_next = (int'(bc_q) > MAX_BODIES) ? CNT_W'(MAX_BODIES) : CNT_W'(bc_q);
	assign i_inc  = CNT_W'(i_q + 1'b1);

	always_comb begin
		case (state_q)
			S_EXEC:  rd_addr = IDX_W'(bidx_q);
			S_J_CHK: rd_addr = j_q[IDX_W-1:0];
			default: rd_addr = i_q[IDX_W-1:0];
		endcase
	end

	assign wr_addr   = (state_q == S_WB) ? i_q[IDX_W-1:0] : IDX_W'(bidx_q);
	assign pos_we    = (state_q == S_WB) ||
		(state_q == S_EXEC && cmd_q == nbg_pkg::CMD_LOAD_POS && idx_ok);
	assign vel_we    = (state_q == S_WB) ||
		(state_q == S_EXEC && cmd_q == nbg_pkg::CMD_LOAD_VEL && idx_ok);
	assign mass_we   = (state_q == S_EXEC && cmd_q == nbg_pkg::CMD_LOAD_MASS && idx_ok);
	assign force_we  = (state_q == S_FADD);
	assign pos_wdata = (state_q == S_WB) ? p_q : vin_q;
	assign vel_wdata = (state_q == S_WB) ? v_q : vin_q;

	// Entries not loaded since reset read as zero mass and cleared flags; a
	// force entry whose valid bit is clear reads as zero.
	assign mass_eff = mvld_rd_q ? mass_rdata[33:2] : 32'd0;
	assign attr_eff = mvld_rd_q & mass_rdata[0];
	assign force_eff = fvld_rd_q ? force_rdata : 96'd0;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			force_wdata[a*32 +: 32] = sat_add(force_eff[a], MW'(mag32(vin_q[a])), vin_q[a][31]);
		end
	end

	always_comb begin
		logic signed [32:0] dx;
		for (int a = 0; a < 3; a++) begin
			dx = $signed({pos_rdata[a*32+31], pos_rdata[a*32 +: 32]}) -
				$signed({p_q[a][31], p_q[a]});
			dx_neg[a] = dx[32];
			dx_mag[a] = dx[32] ? 33'(-dx) : 33'(dx);
		end
	end

	nbg_ram #(.WIDTH(96), .DEPTH(MAX_BODIES)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(wr_addr), .wdata(pos_wdata),
		.raddr(rd_addr), .rdata(pos_rdata)
	);

	nbg_ram #(.WIDTH(96), .DEPTH(MAX_BODIES)) u_vel_ram (
		.clk(clk), .we(vel_we), .waddr(wr_addr), .wdata(vel_wdata),
		.raddr(rd_addr), .rdata(vel_rdata)
	);

	nbg_ram #(.WIDTH(34), .DEPTH(MAX_BODIES)) u_mass_ram (
		.clk(clk), .we(mass_we), .waddr(wr_addr), .wdata({bmass_q, tg_q, ia_q}),
		.raddr(rd_addr), .rdata(mass_rdata)
	);

	nbg_ram #(.WIDTH(96), .DEPTH(MAX_BODIES)) u_force_ram (
		.clk(clk), .we(force_we), .waddr(wr_addr), .wdata(force_wdata),
		.raddr(rd_addr), .rdata(force_rdata)
	);

	// Operand selection for the shared unit.
	always_comb begin
		alu_req.op = nbg_pkg::ALU_MUL;
		alu_a      = '0;
		alu_b      = '0;
		computing  = 1'b1;
		case (state_q)
			S_SQ: begin
				alu_a = nbg_pkg::ALU_A_W'(mg_q[k_q]);
				alu_b = nbg_pkg::ALU_B_W'(mg_q[k_q]);
			end
			S_SQRT: begin
				alu_req.op = nbg_pkg::ALU_SQRT;
				alu_a      = sum_q;
			end
			S_MM: begin
				alu_a = nbg_pkg::ALU_A_W'(mi_q);
				alu_b = nbg_pkg::ALU_B_W'(mj_q);
			end
			S_GM: begin
				alu_a = nbg_pkg::ALU_A_W'(t_q[MW-1:0]);
				alu_b = nbg_pkg::ALU_B_W'(gc_q);
			end
			S_QD, S_FM: begin
				alu_req.op = nbg_pkg::ALU_DIV;
				alu_a      = nbg_pkg::ALU_A_W'({t_q[MW-1:0], {FB{1'b0}}});
				alu_b      = d_q;
			end
			S_U: begin
				alu_req.op = nbg_pkg::ALU_DIV;
				alu_a      = nbg_pkg::ALU_A_W'({mg_q[k_q], {FB{1'b0}}});
				alu_b      = d_q;
			end
			S_C: begin
				alu_a = nbg_pkg::ALU_A_W'(fm_q);
				alu_b = t_q[nbg_pkg::ALU_B_W-1:0];
			end
			S_ACC: begin
				alu_req.op = nbg_pkg::ALU_DIV;
				alu_a      = nbg_pkg::ALU_A_W'({mag32(f_q[k_q]), {FB{1'b0}}});
				alu_b      = nbg_pkg::ALU_B_W'(mi_q);
				computing  = (mi_q != 32'd0);
			end
			S_DP: begin
				alu_a = nbg_pkg::ALU_A_W'(mag32(v_q[k_q]));
				alu_b = nbg_pkg::ALU_B_W'(dt_q);
			end
			default: computing = 1'b0;
		endcase
		alu_req.start = computing && !issued_q;
	end

	assign fin = issued_q && alu_done;

	nbg_alu u_alu (
		.clk(clk), .arst_n(arst_n), .req(alu_req), .opa(alu_a), .opb(alu_b),
		.done(alu_done), .result(alu_res)
	);

	assign in_ready = (state_q == S_IDLE);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			gc_q        <= 32'd0;
			dt_q        <= nbg_pkg::TIME_STEP_RESET;
			bc_q        <= 5'd0;
			mass_vld_q  <= '0;
			force_vld_q <= '0;
			mvld_rd_q   <= 1'b0;
			fvld_rd_q   <= 1'b0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			k_q         <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					nbg_pkg::REG_GRAVITY:    gc_q <= cfg_data;
					nbg_pkg::REG_TIME_STEP:  dt_q <= cfg_data[15:0];
					nbg_pkg::REG_BODY_COUNT: bc_q <= cfg_data[4:0];
					default: ;
				endcase
			end

			mvld_rd_q <= mass_vld_q[rd_addr];
			fvld_rd_q <= force_vld_q[rd_addr];
			if (mass_we) begin
				mass_vld_q[wr_addr] <= 1'b1;
			end
			if (force_we) begin
				force_vld_q[wr_addr] <= 1'b1;
			end

			if (alu_req.start) begin
				issued_q <= 1'b1;
			end else if (fin) begin
				issued_q <= 1'b0;
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q)
						nbg_pkg::CMD_ADD_FORCE: state_q <= idx_ok ? S_FADD : S_IDLE;
						nbg_pkg::CMD_STEP: begin
							n_q     <= n_next;
							i_q     <= '0;
							state_q <= (n_next == '0) ? S_IDLE : S_BODY_RD;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_FADD:    state_q <= S_IDLE;
				S_BODY_RD: state_q <= S_BODY_LD;
				S_BODY_LD: begin
					j_q     <= '0;
					k_q     <= '0;
					state_q <= mass_rdata[1] && mvld_rd_q ? S_J_CHK : S_ACC;
				end
				S_J_CHK: begin
					if (j_q == n_q) begin
						k_q     <= '0;
						state_q <= S_ACC;
					end else begin
						state_q <= S_J_LD;
					end
				end
				S_J_LD: begin
					if (j_q == i_q || !attr_eff) begin
						j_q     <= CNT_W'(j_q + 1'b1);
						state_q <= S_J_CHK;
					end else begin
						k_q     <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (fin) begin
						k_q     <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
						state_q <= (k_q == 2'd2) ? S_SQRT : S_SQ;
					end
				end
				S_SQRT: begin
					if (fin) begin
						state_q <= (alu_res[33:0] == 34'd0) ? S_J_NEXT : S_MM;
					end
				end
				S_MM: if (fin) state_q <= S_GM;
				S_GM: if (fin) state_q <= S_QD;
				S_QD: if (fin) state_q <= S_FM;
				S_FM: begin
					if (fin) begin
						k_q     <= '0;
						state_q <= (cap_mag(alu_res) == '0) ? S_J_NEXT : S_U;
					end
				end
				S_U: if (fin) state_q <= S_C;
				S_C: begin
					if (fin) begin
						k_q     <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
						state_q <= (k_q == 2'd2) ? S_J_NEXT : S_U;
					end
				end
				S_J_NEXT: begin
					j_q     <= CNT_W'(j_q + 1'b1);
					state_q <= S_J_CHK;
				end
				S_ACC: begin
					// A massless body gets no acceleration.
					if (mi_q == 32'd0 || fin) begin
						state_q <= S_DP;
					end
				end
				S_DP: begin
					if (fin) begin
						k_q     <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
						state_q <= (k_q == 2'd2) ? S_WB : S_ACC;
					end
				end
				S_WB: begin
					force_vld_q[i_q[IDX_W-1:0]] <= 1'b0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						i_q         <= i_inc;
						state_q     <= (i_inc == n_q) ? S_IDLE : S_BODY_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q   <= command;
			bidx_q  <= body_index;
			vin_q   <= {vec_z, vec_y, vec_x};
			bmass_q <= body_mass;
			tg_q    <= takes_gravity;
			ia_q    <= is_attractor;
		end

		case (state_q)
			S_BODY_LD: begin
				mi_q <= mass_eff;
				p_q  <= pos_rdata;
				v_q  <= vel_rdata;
				f_q  <= force_eff;
			end
			S_J_LD: begin
				mj_q  <= mass_eff;
				mg_q  <= dx_mag;
				neg_q <= dx_neg;
				sum_q <= '0;
			end
			S_SQ:   if (fin) sum_q <= sum_q + 68'(alu_res[65:0]);
			S_SQRT: if (fin) d_q <= alu_res[33:0];
			S_MM:   if (fin) t_q <= 64'(alu_res[FB +: MW]);
			S_GM:   if (fin) t_q <= 64'(cap_mag(nbg_pkg::ALU_R_W'(alu_res >> FB)));
			S_QD:   if (fin) t_q <= 64'(cap_mag(alu_res));
			S_FM:   if (fin) fm_q <= cap_mag(alu_res);
			S_U:    if (fin) t_q <= alu_res[63:0];
			S_C: begin
				if (fin) begin
					f_q[k_q] <= sat_add(f_q[k_q], alu_res[FB +: MW], neg_q[k_q]);
				end
			end
			S_ACC: begin
				if (fin) begin
					v_q[k_q] <= sat_add(v_q[k_q], alu_res[MW-1:0], f_q[k_q][31]);
				end
			end
			S_DP: begin
				if (fin) begin
					p_q[k_q] <= sat_add(p_q[k_q], MW'(alu_res[16 +: 32]), v_q[k_q][31]);
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_index_q <= 4'(i_q);
					out_pos_q   <= p_q;
					out_vel_q   <= v_q;
					out_last_q  <= (i_inc == n_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign pos_x     = out_pos_q[0];
	assign pos_y     = out_pos_q[1];
	assign pos_z     = out_pos_q[2];
	assign vel_x     = out_vel_q[0];
	assign vel_y     = out_vel_q[1];
	assign vel_z     = out_vel_q[2];
	assign last      = out_last_q;

endmodule

// ===== design/nbg_checker.sv =====
// Port-level checker for the n-body gravity unit, bound to the top level.
// Depends on the top level's port list only.
module nbg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] out_index,
	input logic       last
);

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is still in progress");

	// While a step still has bodies to deliver the block stays busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("block idle in the middle of a step");

	// in_ready only drops after an item has been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("in_ready dropped with no item taken");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(last))
		else $error("stalled result changed");

endmodule

bind nbody_gravity_euler_step_unit nbg_checker u_nbg_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_index(out_index), .last(last)
);

// ===== tb/tb_nbody_gravity_euler_step_unit.sv =====
// Self-checking testbench for nbody_gravity_euler_step_unit: drives load, force and
// step items, predicts each emitted body in fixed point and checks it field by field.
// Depends on nbg_pkg and the block under test; needs no files or arguments.
module tb_nbody_gravity_euler_step_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBODY = 16;
	localparam int WATCHDOG_LIMIT = 60000;
	// Commands above the step code are not defined and must be ignored.
	localparam logic [2:0] CMD_FIRST_UNKNOWN = nbg_pkg::CMD_STEP + 3'd1;
	localparam logic [2:0] CMD_LAST_UNKNOWN = 3'd7;
	localparam longint CAP = (64'd1 << (64 - nbg_pkg::FRAC_BITS)) - 1;
	localparam int INT_MAX = 32'sh7fffffff;
	localparam int INT_MIN = 32'sh80000000;

	typedef struct {
		logic [3:0] idx;
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic lst;
	} body_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] command = '0;
	logic [3:0] body_index = '0;
	logic [31:0] vec_x = '0, vec_y = '0, vec_z = '0, body_mass = '0;
	logic takes_gravity = 1'b0, is_attractor = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] out_index;
	logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
	logic last;

	// Shadow copy of the body table and the registers, kept in step with the block.
	int shadow_pos[NBODY][3];
	int shadow_vel[NBODY][3];
	int shadow_force[NBODY][3];
	logic [31:0] shadow_mass[NBODY];
	bit shadow_grav[NBODY], shadow_attr[NBODY];
	bit pos_loaded[NBODY], vel_loaded[NBODY], mass_loaded[NBODY];
	logic [31:0] grav_const;
	logic [15:0] dt_reg;
	logic [4:0] count_reg;

	body_out_t pending_bodies[$];
	int errors = 0;
	int items_sent = 0;
	int bodies_checked = 0;
	int steps_sent = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	int ready_stall = 0;

	nbody_gravity_euler_step_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .body_index(body_index),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .body_mass(body_mass),
		.takes_gravity(takes_gravity), .is_attractor(is_attractor),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_index(out_index),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.last(last)
	);

	always #1 clk = ~clk;

	// Clamp a wide signed value to the 32-bit range.
	function automatic int sat32(longint v);
		if (v > longint'(INT_MAX)) return INT_MAX;
		if (v < longint'(INT_MIN)) return INT_MIN;
		return int'(v);
	endfunction

	function automatic logic [127:0] cap_mag(logic [127:0] v);
		return (v > 128'(CAP)) ? 128'(CAP) : v;
	endfunction

	// Gravitational pull of attractor j on body i, added to body i's force.
	// All magnitudes are carried at 128 bits so that nothing wraps.
	function automatic void add_pull(int i, int j);
		longint dv[3];
		logic [127:0] mg[3];
		logic [127:0] sq, root, trial, mm, gm, q, fm, u, c;
		sq = '0;
		for (int k = 0; k < 3; k++) begin
			dv[k] = longint'(shadow_pos[j][k]) - longint'(shadow_pos[i][k]);
			mg[k] = 128'(dv[k] < 0 ? -dv[k] : dv[k]);
			sq += mg[k] * mg[k];
		end
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= sq)
				root = trial;
		end
		// Coincident bodies exert nothing on each other.
		if (root == 0)
			return;
		mm = (128'(shadow_mass[i]) * 128'(shadow_mass[j])) >> nbg_pkg::FRAC_BITS;
		gm = cap_mag((128'(grav_const) * mm) >> nbg_pkg::FRAC_BITS);
		q = cap_mag((gm << nbg_pkg::FRAC_BITS) / root);
		fm = cap_mag((q << nbg_pkg::FRAC_BITS) / root);
		if (fm == 0)
			return;
		for (int k = 0; k < 3; k++) begin
			u = (mg[k] << nbg_pkg::FRAC_BITS) / root;
			c = (fm * u) >> nbg_pkg::FRAC_BITS;
			shadow_force[i][k] = sat32(longint'(shadow_force[i][k])
				+ (dv[k] < 0 ? -longint'(c[63:0]) : longint'(c[63:0])));
		end
	endfunction

	// Apply one accepted item to the shadow table; a step queues its bodies.
	function automatic void predict_item(logic [2:0] cmd, logic [3:0] idx, int v[3],
			logic [31:0] m, bit g, bit a);
		int n, f, vv;
		logic [127:0] acc, disp;
		body_out_t r;
		case (cmd)
			nbg_pkg::CMD_LOAD_POS: begin
				for (int k = 0; k < 3; k++) shadow_pos[idx][k] = v[k];
				pos_loaded[idx] = 1'b1;
			end
			nbg_pkg::CMD_LOAD_VEL: begin
				for (int k = 0; k < 3; k++) shadow_vel[idx][k] = v[k];
				vel_loaded[idx] = 1'b1;
			end
			nbg_pkg::CMD_LOAD_MASS: begin
				shadow_mass[idx] = m;
				shadow_grav[idx] = g;
				shadow_attr[idx] = a;
				mass_loaded[idx] = 1'b1;
			end
			nbg_pkg::CMD_ADD_FORCE: begin
				for (int k = 0; k < 3; k++)
					shadow_force[idx][k] = sat32(longint'(shadow_force[idx][k]) + v[k]);
			end
			nbg_pkg::CMD_STEP: begin
				// A count beyond the table size behaves as a full table.
				n = (count_reg > NBODY) ? NBODY : int'(count_reg);
				for (int i = 0; i < n; i++) begin
					if (shadow_grav[i])
						for (int j = 0; j < n; j++)
							if (j != i && shadow_attr[j])
								add_pull(i, j);
					for (int k = 0; k < 3; k++) begin
						f = shadow_force[i][k];
						acc = '0;
						// A massless body keeps its velocity.
						if (shadow_mass[i] != 0)
							acc = (128'(f < 0 ? -longint'(f) : longint'(f))
								<< nbg_pkg::FRAC_BITS) / 128'(shadow_mass[i]);
						vv = sat32(longint'(shadow_vel[i][k])
							+ (f < 0 ? -longint'(acc[63:0]) : longint'(acc[63:0])));
						shadow_vel[i][k] = vv;
						disp = (128'(vv < 0 ? -longint'(vv) : longint'(vv)) * 128'(dt_reg)) >> 16;
						shadow_pos[i][k] = sat32(longint'(shadow_pos[i][k])
							+ (vv < 0 ? -longint'(disp[63:0]) : longint'(disp[63:0])));
						shadow_force[i][k] = 0;
						r.pos[k] = shadow_pos[i][k];
						r.vel[k] = vv;
					end
					r.idx = i[3:0];
					r.lst = (i + 1 == n);
					pending_bodies.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	// Mostly short gaps, now and then a long one, none at all in calm stretches.
	function automatic int pick_gap();
		if (calm)
			return 0;
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(0, 3);
	endfunction

	// Drive one item from a falling edge and hold it until the block takes it.
	task automatic send_item(logic [2:0] cmd, logic [3:0] idx, int v[3],
			logic [31:0] m = '0, bit g = 1'b0, bit a = 1'b0);
		int gap;
		@(negedge clk);
		command = cmd;
		body_index = idx;
		vec_x = v[0];
		vec_y = v[1];
		vec_z = v[2];
		body_mass = m;
		takes_gravity = g;
		is_attractor = a;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		predict_item(cmd, idx, v, m, g, a);
		items_sent++;
		if (cmd == nbg_pkg::CMD_STEP)
			steps_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Let every expected body drain and the block fall idle before touching registers.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_bodies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Registers are only written once the block is idle with nothing outstanding.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		in_valid = 1'b0;
		while (!in_ready || pending_bodies.size() != 0)
			@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			nbg_pkg::REG_GRAVITY: grav_const = value;
			nbg_pkg::REG_TIME_STEP: dt_reg = value[15:0];
			nbg_pkg::REG_BODY_COUNT: count_reg = value[4:0];
			default: ;
		endcase
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? INT_MAX : INT_MIN;
			default: return int'($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_mass();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return $urandom();
			default: return $urandom_range(1, 32'h0004_0000);
		endcase
	endfunction

	// Sends one random load, force or unknown item aimed mostly at bodies in use.
	task automatic send_random_item(int n);
		int v[3];
		logic [3:0] idx;
		int sel;
		for (int k = 0; k < 3; k++) v[k] = rand_coord();
		idx = ($urandom_range(0, 4) == 0 || n == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, n - 1));
		sel = $urandom_range(0, 19);
		if (sel < 5)
			send_item(nbg_pkg::CMD_LOAD_POS, idx, v);
		else if (sel < 9)
			send_item(nbg_pkg::CMD_LOAD_VEL, idx, v);
		else if (sel < 13)
			send_item(nbg_pkg::CMD_LOAD_MASS, idx, v, rand_mass(), $urandom_range(0, 1),
				$urandom_range(0, 1));
		else if (sel < 19)
			send_item(nbg_pkg::CMD_ADD_FORCE, idx, v);
		else
			send_item(3'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN)), idx, v);
	endtask

	// Load whatever position, velocity or mass of the first n bodies is still unwritten.
	task automatic fill_bodies(int n);
		int v[3];
		for (int b = 0; b < n && b < NBODY; b++) begin
			for (int k = 0; k < 3; k++) v[k] = rand_coord();
			if (!pos_loaded[b])
				send_item(nbg_pkg::CMD_LOAD_POS, 4'(b), v);
			if (!vel_loaded[b])
				send_item(nbg_pkg::CMD_LOAD_VEL, 4'(b), v);
			if (!mass_loaded[b])
				send_item(nbg_pkg::CMD_LOAD_MASS, 4'(b), v, rand_mass(), 1'b1,
					$urandom_range(0, 1));
		end
	endtask

	// Directed: empty step, unknown commands, coincident bodies, a massless body,
	// saturating forces and the extreme register values.
	task automatic test_directed();
		int v[3];
		v = '{0, 0, 0};
		calm = 1'b1;
		send_item(nbg_pkg::CMD_STEP, 4'd0, v);
		for (int c = CMD_FIRST_UNKNOWN; c <= CMD_LAST_UNKNOWN; c++)
			send_item(3'(c), 4'd15, '{INT_MAX, INT_MIN, -1});
		calm = 1'b0;
		send_item(nbg_pkg::CMD_LOAD_POS, 4'd0, '{INT_MAX, INT_MIN, 0});
		send_item(nbg_pkg::CMD_LOAD_POS, 4'd1, '{INT_MAX, INT_MIN, 0});
		send_item(nbg_pkg::CMD_LOAD_POS, 4'd2, '{-32'sh0001_0000, 32'sh0003_0000, -1});
		send_item(nbg_pkg::CMD_LOAD_VEL, 4'd0, '{INT_MAX, INT_MIN, -1});
		send_item(nbg_pkg::CMD_LOAD_VEL, 4'd1, '{0, 0, 0});
		send_item(nbg_pkg::CMD_LOAD_VEL, 4'd2, '{INT_MIN, INT_MAX, 1});
		send_item(nbg_pkg::CMD_LOAD_MASS, 4'd0, v, 32'hffff_ffff, 1'b1, 1'b1);
		send_item(nbg_pkg::CMD_LOAD_MASS, 4'd1, v, 32'h0001_0000, 1'b1, 1'b1);
		send_item(nbg_pkg::CMD_LOAD_MASS, 4'd2, v, 32'h0000_0000, 1'b1, 1'b1);
		send_item(nbg_pkg::CMD_ADD_FORCE, 4'd0, '{INT_MAX, INT_MIN, 12345});
		send_item(nbg_pkg::CMD_ADD_FORCE, 4'd0, '{INT_MAX, INT_MIN, -12345});
		send_item(nbg_pkg::CMD_ADD_FORCE, 4'd2, '{INT_MIN, INT_MAX, 7});
		settle();
		write_reg(nbg_pkg::REG_GRAVITY, 32'hffff_ffff);
		write_reg(nbg_pkg::REG_TIME_STEP, 32'h0000_ffff);
		write_reg(nbg_pkg::REG_BODY_COUNT, 32'd3);
		send_item(nbg_pkg::CMD_STEP, 4'd0, v);
		send_item(nbg_pkg::CMD_STEP, 4'd0, v);
		settle();
		write_reg(nbg_pkg::REG_GRAVITY, 32'd0);
		write_reg(nbg_pkg::REG_TIME_STEP, 32'd0);
		send_item(nbg_pkg::CMD_STEP, 4'd0, v);
		settle();
	endtask

	// Whole table in use, then a count beyond the table size.
	task automatic test_full_table();
		int v[3];
		v = '{0, 0, 0};
		write_reg(nbg_pkg::REG_GRAVITY, 32'h0001_0000);
		write_reg(nbg_pkg::REG_TIME_STEP, 32'd1092);
		fill_bodies(NBODY);
		write_reg(nbg_pkg::REG_BODY_COUNT, 32'd16);
		send_item(nbg_pkg::CMD_STEP, 4'd0, v);
		settle();
		write_reg(nbg_pkg::REG_BODY_COUNT, 32'd31);
		send_item(nbg_pkg::CMD_STEP, 4'd0, v);
		settle();
	endtask

	// Random phases: new registers, a few loads and forces, then one or two steps.
	task automatic test_random_phases();
		int n;
		int v[3];
		while (items_sent < 280) begin
			calm = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 4))
				0: write_reg(nbg_pkg::REG_GRAVITY, 32'd0);
				1: write_reg(nbg_pkg::REG_GRAVITY, 32'hffff_ffff);
				2: write_reg(nbg_pkg::REG_GRAVITY, $urandom());
				default: write_reg(nbg_pkg::REG_GRAVITY, $urandom_range(32'h100, 32'h0010_0000));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(nbg_pkg::REG_TIME_STEP,
					$urandom_range(0, 1) ? 32'h0000_ffff : 32'd0);
				default: write_reg(nbg_pkg::REG_TIME_STEP, $urandom_range(0, 16'hffff));
			endcase
			n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 6) : $urandom_range(1, 4);
			fill_bodies(n);
			write_reg(nbg_pkg::REG_BODY_COUNT, 32'(n));
			repeat ($urandom_range(3, 8)) send_random_item(n);
			v = '{0, 0, 0};
			fill_bodies(n);
			repeat ($urandom_range(1, 2))
				send_item(nbg_pkg::CMD_STEP, 4'($urandom_range(0, 15)), v);
			settle();
		end
	endtask

	// Result stall: mostly ready, with random gaps of varying length.
	always @(negedge clk) begin
		if (calm) begin
			out_ready = 1'b1;
		end else if (ready_stall > 0) begin
			out_ready = 1'b0;
			ready_stall--;
		end else begin
			out_ready = 1'b1;
			if ($urandom_range(0, 5) == 0)
				ready_stall = pick_gap();
		end
	end

	// Each accepted body is compared with the oldest expectation.
	always @(posedge clk) begin
		body_out_t e;
		if (out_valid && out_ready) begin
			bodies_checked++;
			if (pending_bodies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected body %0d at %0t", out_index, $realtime);
			end else begin
				e = pending_bodies.pop_front();
				if (out_index !== e.idx || last !== e.lst
						|| {pos_x, pos_y, pos_z} !== {e.pos[0], e.pos[1], e.pos[2]}
						|| {vel_x, vel_y, vel_z} !== {e.vel[0], e.vel[1], e.vel[2]}) begin
					errors++;
					if (errors <= 10) begin
						$display("body mismatch: expected idx %0d last %0b pos %h %h %h vel %h %h %h",
							e.idx, e.lst, e.pos[0], e.pos[1], e.pos[2],
							e.vel[0], e.vel[1], e.vel[2]);
						$display("                got idx %0d last %0b pos %h %h %h vel %h %h %h",
							out_index, last, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z);
					end
				end
			end
		end
	end

	// Watchdog: a long spell with nothing taken on either channel means a hang.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d bodies outstanding", pending_bodies.size());
			$display("tb_nbody_gravity_euler_step_unit: done, errors");
			$finish;
		end
	end

	initial begin
		grav_const = '0;
		dt_reg = nbg_pkg::TIME_STEP_RESET;
		count_reg = '0;
		for (int b = 0; b < NBODY; b++) begin
			shadow_grav[b] = 1'b0;
			shadow_attr[b] = 1'b0;
			shadow_mass[b] = '0;
			for (int k = 0; k < 3; k++) begin
				shadow_pos[b][k] = 0;
				shadow_vel[b][k] = 0;
				shadow_force[b][k] = 0;
			end
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_full_table();
		test_random_phases();
		settle();
		$display("covered %0d items including %0d steps; %0d bodies checked",
			items_sent, steps_sent, bodies_checked);
		$display("mismatches or stray bodies: %0d", errors + pending_bodies.size());
		if (errors == 0 && pending_bodies.size() == 0)
			$display("tb_nbody_gravity_euler_step_unit: done, clean");
		else
			$display("tb_nbody_gravity_euler_step_unit: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/nbg_pkg.sv
design/nbg_ram.sv
design/nbg_alu.sv
design/nbody_gravity_euler_step_unit.sv
design/nbg_checker.sv
tb/tb_nbody_gravity_euler_step_unit.sv
